>>> rtl/prjq_pkg.sv
// prjq_pkg: shared types and constants of the priority rotating job queue
// used by prjq_ctrl, prjq_datapath and the top level; no dependencies
package prjq_pkg;

    localparam int OP_W        = 2;
    localparam int PRIO_W      = 4;
    localparam int ORD_W       = 8;
    localparam int STAT_W      = 2;
    localparam int SLOT_W      = PRIO_W + ORD_W;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_SERVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ROT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic scan;
        logic rot_init;
        logic rot;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic serve_go;
        logic scan_done;
        logic rot_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/priority_rotating_job_queue_top.sv
// priority_rotating_job_queue_top: job queue served highest priority first with rotation
// depends on prjq_pkg, prjq_ctrl, prjq_datapath and prjq_ram
//
// Input stream s_axis carries one command item: add a job, serve the best job or clear.
// Output stream m_axis returns exactly one result item per command, in order.
// i_cfg_we/i_cfg_wdata write the target ordinal; write only while the queue is idle.
// Jobs live in a ring of DEPTH slots held in one single-port-read ram.
// Add, clear and no-op go from the idle state to the finish state, where the result
// is written into the output register once that register is free.
// Serve runs a maximum scan over all queued jobs (one ram read per cycle), then
// copies the jobs ahead of the winner to the tail (one ram read and write per
// cycle), and a finish step commits the result. One command is worked on at a time.
// s_axis_tready is high only while the sequencer is idle; a new command is taken
// while the previous result still waits in the output register.
// If m_axis_tready stays low, the finished command waits before commit and the
// queue takes no further commands.
// Reset (synchronous, active low) empties the queue, restarts ordinals and serve
// numbers at zero and clears the target ordinal; no clearing pass is needed.
module priority_rotating_job_queue_top #(
    parameter int DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [1:0] opcode, [5:2] job_priority
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [1:0] status, [9:2] job_ordinal,
                                        // [17:10] serve_number, [18] is_target
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    import prjq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    prjq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    prjq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule

>>> rtl/prjq_ram.sv
// prjq_ram: generic single write port, single read port ram with registered read
// no dependencies
module prjq_ram #(
    parameter int  WIDTH = 12,
    parameter int  DEPTH = 128,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/prjq_ctrl.sv
// prjq_ctrl: sequencer of the job queue (idle, scan, rotate, finish)
// depends on prjq_pkg; drives the datapath by command struct
module prjq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  prjq_pkg::t_dp_stat i_stat,
    output prjq_pkg::t_dp_cmd  o_cmd
);

    import prjq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.serve_go ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                if (i_stat.rot_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan     = 1'b1;
                o_cmd.rot_init = i_stat.scan_done;
            end
            S_ROT: begin
                o_cmd.rot = 1'b1;
            end
            S_FINISH: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> rtl/prjq_datapath.sv
// prjq_datapath: ring pointers, counters, slot ram, scan and rotate logic, result register
// depends on prjq_pkg and prjq_ram
module prjq_datapath #(
    parameter int  DEPTH = 128,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  prjq_pkg::t_dp_cmd                   i_cmd,
    output prjq_pkg::t_dp_stat                  o_stat,
    input  logic [prjq_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  logic                                i_cfg_we,
    input  logic [prjq_pkg::ORD_W-1:0]          i_cfg_wdata,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [prjq_pkg::OUT_TDATA_W-1:0]    o_out_data
);

    import prjq_pkg::*;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        q = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
        return q;
    endfunction

    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [ORD_W-1:0]  r_next_ord, n_next_ord;
    logic [ORD_W-1:0]  r_served, n_served;
    logic [ORD_W-1:0]  r_target, n_target;
    logic              r_out_valid, n_out_valid;
    logic              r_dv, n_dv;

    logic [OP_W-1:0]   r_op, n_op;
    logic [PRIO_W-1:0] r_prio, n_prio;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_dk, n_dk;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]     r_best_idx, n_best_idx;
    logic [PRIO_W-1:0] r_best_prio, n_best_prio;
    logic [ORD_W-1:0]  r_best_ord, n_best_ord;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [SLOT_W-1:0] mem_wdata;
    logic [SLOT_W-1:0] mem_rdata;
    logic [PRIO_W-1:0] rd_prio;
    logic [ORD_W-1:0]  rd_ord;
    logic              issue_scan;
    logic              issue_rot;
    logic              full;
    logic              empty;
    logic [ORD_W-1:0]  served_inc;

    prjq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_rd_ptr),
        .o_rdata (mem_rdata)
    );

    assign rd_prio    = mem_rdata[PRIO_W-1:0];
    assign rd_ord     = mem_rdata[SLOT_W-1:PRIO_W];
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign issue_scan = i_cmd.scan && (r_idx < r_count);
    assign issue_rot  = i_cmd.rot && (r_idx < r_best_idx);
    assign served_inc = r_served + ORD_W'(1);

    assign o_stat.serve_go  = (i_in_data[OP_W-1:0] == OP_SERVE) && !empty;
    assign o_stat.scan_done = (r_idx == r_count) && !r_dv;
    assign o_stat.rot_done  = (r_idx == r_best_idx) && !r_dv;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_next_ord  = r_next_ord;
        n_served    = r_served;
        n_target    = r_target;
        n_out_valid = r_out_valid;
        n_dv        = r_dv;
        n_op        = r_op;
        n_prio      = r_prio;
        n_idx       = r_idx;
        n_dk        = r_dk;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_best_idx  = r_best_idx;
        n_best_prio = r_best_prio;
        n_best_ord  = r_best_ord;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_waddr   = r_wr_ptr;
        mem_wdata   = mem_rdata;

        if (i_cfg_we) begin
            n_target = i_cfg_wdata;
        end

        if (i_cmd.load) begin
            n_op     = i_in_data[OP_W-1:0];
            n_prio   = i_in_data[OP_W+PRIO_W-1:OP_W];
            n_idx    = '0;
            n_rd_ptr = r_head;
            n_wr_ptr = r_tail;
            n_dv     = 1'b0;
        end

        // max search from the head, earliest wins on ties
        if (i_cmd.scan) begin
            if (issue_scan) begin
                n_rd_ptr = ptr_inc(r_rd_ptr);
                n_idx    = r_idx + CW'(1);
            end
            n_dv = issue_scan;
            n_dk = r_idx;
            if (r_dv && ((r_dk == '0) || (rd_prio > r_best_prio))) begin
                n_best_idx  = r_dk;
                n_best_prio = rd_prio;
                n_best_ord  = rd_ord;
            end
        end

        if (i_cmd.rot_init) begin
            n_idx    = '0;
            n_rd_ptr = r_head;
            n_dv     = 1'b0;
        end

        // copy jobs ahead of the winner to the tail
        if (i_cmd.rot) begin
            if (issue_rot) begin
                n_rd_ptr = ptr_inc(r_rd_ptr);
                n_idx    = r_idx + CW'(1);
            end
            n_dv = issue_rot;
            if (r_dv) begin
                mem_we    = 1'b1;
                mem_waddr = r_wr_ptr;
                mem_wdata = mem_rdata;
                n_wr_ptr  = ptr_inc(r_wr_ptr);
            end
        end

        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
            n_out_data  = '0;
            case (r_op)
                OP_ADD: begin
                    if (full) begin
                        n_out_data[STAT_W-1:0] = STAT_FULL;
                    end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = r_tail;
                        mem_wdata  = {r_next_ord, r_prio};
                        n_out_data[STAT_W+ORD_W-1:STAT_W] = r_next_ord;
                        n_next_ord = r_next_ord + ORD_W'(1);
                        n_tail     = ptr_inc(r_tail);
                        n_count    = r_count + CW'(1);
                    end
                end
                OP_SERVE: begin
                    if (empty) begin
                        n_out_data[STAT_W-1:0] = STAT_EMPTY;
                    end else begin
                        n_out_data[STAT_W+ORD_W-1:STAT_W]           = r_best_ord;
                        n_out_data[STAT_W+2*ORD_W-1:STAT_W+ORD_W]   = served_inc;
                        n_out_data[STAT_W+2*ORD_W]                  = (r_best_ord == r_target);
                        n_served = served_inc;
                        n_head   = ptr_inc(r_rd_ptr);
                        n_tail   = r_wr_ptr;
                        n_count  = r_count - CW'(1);
                    end
                end
                OP_CLEAR: begin
                    n_head     = '0;
                    n_tail     = '0;
                    n_count    = '0;
                    n_next_ord = '0;
                    n_served   = '0;
                end
                default: begin
                    n_out_data = '0;
                end
            endcase
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_next_ord  <= '0;
            r_served    <= '0;
            r_target    <= '0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_next_ord  <= n_next_ord;
            r_served    <= n_served;
            r_target    <= n_target;
            r_out_valid <= n_out_valid;
            r_dv        <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_prio      <= n_prio;
        r_idx       <= n_idx;
        r_dk        <= n_dk;
        r_rd_ptr    <= n_rd_ptr;
        r_wr_ptr    <= n_wr_ptr;
        r_best_idx  <= n_best_idx;
        r_best_prio <= n_best_prio;
        r_best_ord  <= n_best_ord;
        r_out_data  <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
